// ----- hw/rtl/lfo_waveform_generator_unit_macros.svh -----
// Assertion macros used by the LFO waveform generator top level.
`ifndef LFO_WAVEFORM_GENERATOR_UNIT_MACROS_SVH
`define LFO_WAVEFORM_GENERATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is high.
`define LFO_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lfo check failed");

// Clocked check that also holds during reset.
`define LFO_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lfo check failed");

`else

`define LFO_ASSERT(label, clk, rst, prop)
`define LFO_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hw/rtl/lfo_pkg.sv -----
// Shared types, codes and the quarter-sine table builder for the LFO.
`timescale 1ns / 1ps

package lfo_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int LEVEL_BITS     = 16;
   localparam int AMP_BITS       = 15;
   localparam logic [AMP_BITS-1:0] AMP_RESET = 15'h7FFF;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      MODE_TICK        = 2'd0,
      MODE_PHASE_RESET = 2'd1,
      MODE_TRIGGER     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      WAVE_SINE = 2'd0,
      WAVE_DOWN = 2'd1,
      WAVE_UP   = 2'd2,
      WAVE_HOLD = 2'd3
   } wave_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_STEP  = 2'd0,
      REG_WAVE_SELECT = 2'd1,
      REG_AMPLITUDE   = 2'd2
   } reg_index_type;

   // What the output stage does with the held level.
   typedef enum logic [1:0] {
      OP_KEEP   = 2'd0,
      OP_WAVE   = 2'd1,
      OP_SAMPLE = 2'd2
   } op_type;

   // Item state handed from the phase stage to the output stage.
   typedef struct packed {
      op_type                 op;
      logic [LEVEL_BITS-1:0]  top16;
      logic                   negate;
      logic [LEVEL_BITS-1:0]  sample;
      logic                   half_cycle;
      logic                   full_cycle;
   } stage_type;

   // term * x^2 in Q30
   function automatic logic [63:0] sq_step(logic [63:0] term, logic [63:0] x);
      logic [63:0] t;
      t = (term * x) >> 30;
      t = (t * x) >> 30;
      return t;
   endfunction

   // Entry i of the quarter-sine table, 2^depth_log2 entries, Taylor series in Q30.
   // Evaluated only with constant arguments when the table is built.
   function automatic logic [LEVEL_BITS-1:0] quarter_sine_entry(int unsigned idx,
                                                               int unsigned depth_log2);
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      longint      v;
      x    = (64'(2 * idx + 1) * HALF_PI_Q30) >> (depth_log2 + 1);
      term = x;
      sum  = longint'(x);
      term = sq_step(term, x) / 64'd6;
      sum  = sum - longint'(term);
      term = sq_step(term, x) / 64'd20;
      sum  = sum + longint'(term);
      term = sq_step(term, x) / 64'd42;
      sum  = sum - longint'(term);
      term = sq_step(term, x) / 64'd72;
      sum  = sum + longint'(term);
      term = sq_step(term, x) / 64'd110;
      sum  = sum - longint'(term);
      term = sq_step(term, x) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
      if (v > 32767) begin
         v = 32767;
      end
      return v[LEVEL_BITS-1:0];
   endfunction

endpackage

// ----- hw/rtl/lfo_phase.sv -----
// Phase accumulator, cycle flags and ROM address generation for the LFO.
`timescale 1ns / 1ps

module lfo_phase #(
   parameter int PHASE_BITS = 32,
   parameter int ADDR_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        mode,
   input  logic [lfo_pkg::LEVEL_BITS-1:0]    hold_sample,
   input  logic [PHASE_BITS-1:0]             phase_step,
   input  lfo_pkg::wave_type                 wave_select,
   output lfo_pkg::stage_type                stage_ff,
   output logic [ADDR_BITS-1:0]              rom_addr
);

   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;
   logic                  half_done_ff;
   logic                  half_done_in;
   logic [PHASE_BITS:0]   phase_sum;
   lfo_pkg::stage_type    stage_in;
   logic [1:0]            quad;
   logic [ADDR_BITS-1:0]  idx;

   assign phase_sum = {1'b0, phase_acc_ff} + {1'b0, phase_step};

   always_comb begin
      phase_acc_in        = phase_acc_ff;
      half_done_in        = half_done_ff;
      stage_in.op         = lfo_pkg::OP_KEEP;
      stage_in.half_cycle = 1'b0;
      stage_in.full_cycle = 1'b0;
      stage_in.sample     = hold_sample;
      case (lfo_pkg::mode_type'(mode))
         lfo_pkg::MODE_TICK: begin
            if (wave_select != lfo_pkg::WAVE_HOLD) begin
               stage_in.op         = lfo_pkg::OP_WAVE;
               phase_acc_in        = phase_sum[PHASE_BITS-1:0];
               stage_in.full_cycle = phase_sum[PHASE_BITS];
               if (phase_sum[PHASE_BITS]) begin
                  half_done_in = 1'b0;
               end else if (phase_sum[PHASE_BITS-1] && !half_done_ff) begin
                  half_done_in        = 1'b1;
                  stage_in.half_cycle = 1'b1;
               end
            end
         end
         lfo_pkg::MODE_PHASE_RESET: begin
            phase_acc_in = '0;
            half_done_in = 1'b0;
         end
         lfo_pkg::MODE_TRIGGER: begin
            if (wave_select == lfo_pkg::WAVE_HOLD) begin
               stage_in.op = lfo_pkg::OP_SAMPLE;
            end
         end
         default: begin
         end
      endcase
      quad            = phase_acc_in[PHASE_BITS-1 -: 2];
      idx             = phase_acc_in[PHASE_BITS-3 -: ADDR_BITS];
      stage_in.top16  = phase_acc_in[PHASE_BITS-1 -: lfo_pkg::LEVEL_BITS];
      stage_in.negate = quad[1];
   end

   // Odd quadrants read the table mirrored.
   assign rom_addr = quad[0] ? ~idx : idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         half_done_ff <= 1'b0;
      end else if (accept) begin
         phase_acc_ff <= phase_acc_in;
         half_done_ff <= half_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ----- hw/rtl/lfo_sine_rom.sv -----
// Quarter-wave sine table with registered read.
`timescale 1ns / 1ps

module lfo_sine_rom #(
   parameter int ADDR_BITS = 8
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [ADDR_BITS-1:0]            rd_addr,
   output logic [lfo_pkg::LEVEL_BITS-1:0]  rd_data_ff
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [lfo_pkg::LEVEL_BITS-1:0] rom_mem [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      assign rom_mem[i] = lfo_pkg::quarter_sine_entry(i, ADDR_BITS);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/lfo_shaper.sv -----
// Waveform select, amplitude scaling and held level register of the LFO.
`timescale 1ns / 1ps

module lfo_shaper (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  lfo_pkg::stage_type                     stage,
   input  logic [lfo_pkg::LEVEL_BITS-1:0]         rom_data,
   input  lfo_pkg::wave_type                      wave_select,
   input  logic [lfo_pkg::AMP_BITS-1:0]           amplitude,
   output logic signed [lfo_pkg::LEVEL_BITS-1:0]  held_level_ff,
   output logic                                   half_cycle_ff,
   output logic                                   full_cycle_ff
);

   localparam int PROD_BITS = 2 * lfo_pkg::LEVEL_BITS;

   logic signed [lfo_pkg::LEVEL_BITS-1:0] base;
   logic signed [PROD_BITS-1:0]           product;
   logic signed [PROD_BITS-1:0]           scaled;
   logic signed [lfo_pkg::LEVEL_BITS-1:0] held_level_in;

   always_comb begin
      if (stage.op == lfo_pkg::OP_SAMPLE) begin
         // offset binary to two's complement
         base = {~stage.sample[15], stage.sample[14:0]};
      end else begin
         case (wave_select)
            lfo_pkg::WAVE_DOWN: base = {stage.top16[15], ~stage.top16[14:0]};
            lfo_pkg::WAVE_UP:   base = {~stage.top16[15], stage.top16[14:0]};
            default: begin
               base = stage.negate ? -$signed(rom_data) : $signed(rom_data);
            end
         endcase
      end
   end

   // Round half up, then floor by the arithmetic shift.
   assign product = base * $signed({1'b0, amplitude}) + PROD_BITS'(16384);
   assign scaled  = product >>> 15;

   assign held_level_in = (stage.op == lfo_pkg::OP_KEEP) ?
                          held_level_ff : scaled[lfo_pkg::LEVEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         held_level_ff <= '0;
      end else if (load) begin
         held_level_ff <= held_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         half_cycle_ff <= stage.half_cycle;
         full_cycle_ff <= stage.full_cycle;
      end
   end

endmodule

// ----- hw/rtl/lfo_waveform_generator_unit.sv -----
// Top level of the LFO waveform generator: handshake, CSRs and pipeline.
`timescale 1ns / 1ps

// LFO waveform generator. Each request transfer carries a mode (tick, phase
// reset, sample-hold trigger) and yields exactly one response transfer with
// the current level as Q1.15 (rsp_level) and offset binary (rsp_level_unsigned),
// plus half and full cycle flags. The unit takes one request per cycle unless
// req_stall is high; each item passes the first stage register and then the
// output register before its response is valid. The sine table read is
// registered, which sets the two-stage depth, and one 16x16 multiplier in the
// output stage does the amplitude scaling. A waiting response
// does not block the next request: one more item can sit in the first stage.
// CSR writes (phase_step, wave_select, amplitude) are always ready and must
// be issued only while the unit is idle. SINE_TABLE_DEPTH must be a power of two.

`include "lfo_waveform_generator_unit_macros.svh"

module lfo_waveform_generator_unit #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_mode,
   input  logic [lfo_pkg::LEVEL_BITS-1:0]         req_hold_sample,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lfo_pkg::LEVEL_BITS-1:0]  rsp_level,
   output logic [lfo_pkg::LEVEL_BITS-1:0]         rsp_level_unsigned,
   output logic                                   rsp_half_cycle,
   output logic                                   rsp_full_cycle,
   // CSR write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lfo_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lfo_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);

   // CSRs
   logic [PHASE_BITS-1:0]          phase_step_ff;
   logic [PHASE_BITS-1:0]          phase_step_in;
   lfo_pkg::wave_type              wave_select_ff;
   lfo_pkg::wave_type              wave_select_in;
   logic [lfo_pkg::AMP_BITS-1:0]   amplitude_ff;
   logic [lfo_pkg::AMP_BITS-1:0]   amplitude_in;

   // pipeline control
   logic                           stage_valid_ff;
   logic                           stage_valid_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           req_accept;
   logic                           out_load;
   logic                           stage_free;

   lfo_pkg::stage_type             stage;
   logic [ADDR_BITS-1:0]           rom_addr;
   logic [lfo_pkg::LEVEL_BITS-1:0] rom_data;
   logic signed [lfo_pkg::LEVEL_BITS-1:0] held_level;

   // ---------------------------------------------------------------------
   // CSR writes: always ready, unknown indexes are dropped.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      phase_step_in  = phase_step_ff;
      wave_select_in = wave_select_ff;
      amplitude_in   = amplitude_ff;
      if (csr_valid && csr_ready) begin
         case (lfo_pkg::reg_index_type'(csr_index))
            lfo_pkg::REG_PHASE_STEP:  phase_step_in  = PHASE_BITS'(csr_wdata);
            lfo_pkg::REG_WAVE_SELECT: wave_select_in = lfo_pkg::wave_type'(csr_wdata[1:0]);
            lfo_pkg::REG_AMPLITUDE:   amplitude_in   = csr_wdata[lfo_pkg::AMP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         wave_select_ff <= lfo_pkg::WAVE_SINE;
         amplitude_ff   <= lfo_pkg::AMP_RESET;
      end else begin
         phase_step_ff  <= phase_step_in;
         wave_select_ff <= wave_select_in;
         amplitude_ff   <= amplitude_in;
      end
   end

   // ---------------------------------------------------------------------
   // Flow control. The output register loads when the first stage holds an item
   // and the output is empty or its transfer completes this cycle; the first stage
   // frees up when it is empty or moves on. Stall the requester when neither holds.
   // ---------------------------------------------------------------------
   assign out_load   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign stage_free = !stage_valid_ff || out_load;
   assign req_stall  = !stage_free;
   assign req_accept = req_valid && stage_free;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (out_load) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: advance the phase on accept, capture the item, read the table.
   // ---------------------------------------------------------------------
   lfo_phase #(
      .PHASE_BITS (PHASE_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .mode        (req_mode),
      .hold_sample (req_hold_sample),
      .phase_step  (phase_step_ff),
      .wave_select (wave_select_ff),
      .stage_ff    (stage),
      .rom_addr    (rom_addr)
   );

   lfo_sine_rom #(
      .ADDR_BITS (ADDR_BITS)
   ) u_sine_rom (
      .clock      (clock),
      .rd_en      (req_accept),
      .rd_addr    (rom_addr),
      .rd_data_ff (rom_data)
   );

   // ---------------------------------------------------------------------
   // Stage 2: shape, scale and hold the level; this is the output register.
   // ---------------------------------------------------------------------
   lfo_shaper u_shaper (
      .clock         (clock),
      .reset         (reset),
      .load          (out_load),
      .stage         (stage),
      .rom_data      (rom_data),
      .wave_select   (wave_select_ff),
      .amplitude     (amplitude_ff),
      .held_level_ff (held_level),
      .half_cycle_ff (rsp_half_cycle),
      .full_cycle_ff (rsp_full_cycle)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level          = held_level;
   // flip the sign bit for offset binary
   assign rsp_level_unsigned = {~held_level[15], held_level[14:0]};

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // wrap suppresses the midpoint flag on the same tick
   `LFO_ASSERT(a_flags_exclusive, clock, reset, rsp_valid |-> !(rsp_half_cycle && rsp_full_cycle))
   // scaling with rounding never reaches the most negative code
   `LFO_ASSERT(a_level_range, clock, reset, rsp_valid |-> (rsp_level != 16'sh8000))
   // an accepted request always lands in the first stage
   `LFO_ASSERT(a_accept_fills, clock, reset, (req_valid && !req_stall) |=> stage_valid_ff)
   // nothing reaches the output without an item in the first stage
   `LFO_ASSERT_ALWAYS(a_out_from_stage, clock, out_load |-> stage_valid_ff)

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the LFO waveform generator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;

   // Codes outside the package enums: the spare request mode and the spare register slot.
   localparam logic [1:0]                         MODE_UNUSED = 2'd3;
   localparam logic [lfo_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED  = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 400_000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int          SINE_ENTRIES = 256;
   localparam int          RANDOM_PHASES = 25;

   // One response transfer as the unit should present it.
   typedef struct packed {
      logic signed [lfo_pkg::LEVEL_BITS-1:0] level;
      logic [lfo_pkg::LEVEL_BITS-1:0]        level_unsigned;
      logic                                  half_cycle;
      logic                                  full_cycle;
   } level_result_type;

   // One row of the directed table: either a CSR write or a request transfer.
   // Rows with known set carry a hand-derived response; the rest use the predictor.
   typedef struct packed {
      logic                                  is_write;
      logic [1:0]                            target;   // register index or request mode
      logic [31:0]                           value;    // write data or hold sample
      logic                                  known;
      logic signed [lfo_pkg::LEVEL_BITS-1:0] level;
      logic [lfo_pkg::LEVEL_BITS-1:0]        level_unsigned;
      logic                                  half_cycle;
      logic                                  full_cycle;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 38;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // out of reset: phase reset shows the cleared hold level
      '{1'b0, lfo_pkg::MODE_PHASE_RESET, 32'h0,    1'b1, 16'sd0, 16'h8000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0,    1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, MODE_UNUSED,               32'hFFFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      // up ramp, quarter-turn step; upper write bits are junk
      '{1'b1, lfo_pkg::REG_WAVE_SELECT, 32'hFFFF_FFFE, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b1, lfo_pkg::REG_PHASE_STEP,  32'h4000_0000, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_PHASE_RESET, 32'h0, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK, 32'h0,    1'b1, -16'sd16383, 16'h4001, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK, 32'hFFFF, 1'b1, 16'sd0,      16'h8000, 1'b1, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK, 32'h0,    1'b1, 16'sd16384,  16'hC000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK, 32'h0,    1'b1, -16'sd32767, 16'h0001, 1'b0, 1'b1},
      // largest step, down ramp, zero gain: each tick after the first wraps past midpoint
      '{1'b1, lfo_pkg::REG_PHASE_STEP,  32'hFFFF_FFFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b1, lfo_pkg::REG_WAVE_SELECT, 32'h0000_0001, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b1, lfo_pkg::REG_AMPLITUDE,   32'hFFFF_8000, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_PHASE_RESET, 32'h0, 1'b1, -16'sd32767, 16'h0001, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0, 1'b1, 16'sd0,      16'h8000, 1'b1, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0, 1'b1, 16'sd0,      16'h8000, 1'b0, 1'b1},
      // trigger while not holding is dropped
      '{1'b0, lfo_pkg::MODE_TRIGGER, 32'h1234, 1'b1, 16'sd0, 16'h8000, 1'b0, 1'b0},
      // sample and hold at full gain
      '{1'b1, lfo_pkg::REG_WAVE_SELECT, 32'hFFFF_FFFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b1, lfo_pkg::REG_AMPLITUDE,   32'h0000_7FFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,    32'h0,    1'b1, 16'sd0,      16'h8000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TRIGGER, 32'h0000, 1'b1, -16'sd32767, 16'h0001, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TRIGGER, 32'hFFFF, 1'b1, 16'sd32766,  16'hFFFE, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TRIGGER, 32'h8000, 1'b1, 16'sd0,      16'h8000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,    32'h0,    1'b1, 16'sd0,      16'h8000, 1'b0, 1'b0},
      '{1'b0, MODE_UNUSED,           32'h0,    1'b1, 16'sd0,      16'h8000, 1'b0, 1'b0},
      // smallest nonzero gain: rounding half up on both signs
      '{1'b1, lfo_pkg::REG_AMPLITUDE, 32'h0000_0001, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TRIGGER, 32'h0000, 1'b1, -16'sd1, 16'h7FFF, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TRIGGER, 32'hFFFF, 1'b1, 16'sd1,  16'h8001, 1'b0, 1'b0},
      // sine at the quadrant edges, mirrored and negated quadrants
      '{1'b1, lfo_pkg::REG_WAVE_SELECT, 32'h0000_0000, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b1, lfo_pkg::REG_AMPLITUDE,   32'h0000_7FFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b1, lfo_pkg::REG_PHASE_STEP,  32'h3FFF_FFFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_PHASE_RESET, 32'h0, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK,        32'h0, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      // write to the spare slot must leave every register alone
      '{1'b1, REG_UNUSED,         32'hFFFF_FFFF, 1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0},
      '{1'b0, lfo_pkg::MODE_TICK, 32'h0,         1'b0, 16'sd0, 16'h0000, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid       = 1'b0;
   logic                                  req_stall;
   logic [1:0]                            req_mode        = lfo_pkg::MODE_TICK;
   logic [lfo_pkg::LEVEL_BITS-1:0]        req_hold_sample = '0;

   logic                                  rsp_valid;
   logic                                  rsp_stall       = 1'b0;
   logic signed [lfo_pkg::LEVEL_BITS-1:0] rsp_level;
   logic [lfo_pkg::LEVEL_BITS-1:0]        rsp_level_unsigned;
   logic                                  rsp_half_cycle;
   logic                                  rsp_full_cycle;

   logic                                  csr_valid       = 1'b0;
   logic                                  csr_ready;
   logic [lfo_pkg::CSR_INDEX_BITS-1:0]    csr_index       = lfo_pkg::REG_PHASE_STEP;
   logic [lfo_pkg::CSR_DATA_BITS-1:0]     csr_wdata       = '0;

   lfo_waveform_generator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_hold_sample    (req_hold_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level          (rsp_level),
      .rsp_level_unsigned (rsp_level_unsigned),
      .rsp_half_cycle     (rsp_half_cycle),
      .rsp_full_cycle     (rsp_full_cycle),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: registers as written, plus the oscillator's own state.
   logic [31:0]                  cfg_step      = '0;
   lfo_pkg::wave_type            cfg_wave      = lfo_pkg::WAVE_SINE;
   logic [lfo_pkg::AMP_BITS-1:0] cfg_gain      = lfo_pkg::AMP_RESET;
   logic [31:0]                  lfo_phase     = '0;
   logic                         midpoint_seen = 1'b0;
   logic signed [15:0]           last_level    = '0;
   logic [15:0]                  quarter_wave [SINE_ENTRIES];

   level_result_type pending_levels [$];
   int unsigned      mismatches  = 0;
   int unsigned      cycle_count = 0;

   // Sender burst control and receiver stall pattern.
   bit            gaps_enabled  = 1'b1;
   int unsigned   burst_left    = 0;
   int unsigned   stall_pattern = 0;
   int unsigned   pattern_age   = 0;
   int unsigned   stall_hold    = 0;

   // Quarter-wave sine entry: Taylor series to x^13 in Q30, then round to Q0.15.
   function automatic logic [15:0] quarter_wave_value(int unsigned i);
      logic [63:0] angle;
      logic [63:0] power;
      longint      acc;
      longint      rounded;
      angle = (64'(2 * i + 1) * lfo_pkg::HALF_PI_Q30) / 64'(2 * SINE_ENTRIES);
      power = angle;
      acc   = longint'(angle);
      for (int k = 1; k <= 6; k++) begin
         power = (power * angle) >> 30;
         power = (power * angle) >> 30;
         power = power / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(power);
         end else begin
            acc = acc + longint'(power);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = (acc * 32767 + (longint'(1) << 29)) / (longint'(1) << 30);
      if (rounded > 32767) begin
         rounded = 32767;
      end
      return rounded[15:0];
   endfunction

   // Q1.15 base times Q0.15 gain, rounded half up (floor after adding half an LSB).
   function automatic logic signed [15:0] apply_gain(int base,
                                                    logic [lfo_pkg::AMP_BITS-1:0] gain);
      longint product;
      product = longint'(base) * longint'(gain) + 64'sd16384;
      return 16'(product >>> 15);
   endfunction

   function automatic void apply_csr(logic [lfo_pkg::CSR_INDEX_BITS-1:0] index,
                                     logic [31:0] data);
      case (index)
         lfo_pkg::REG_PHASE_STEP:  cfg_step = data;
         lfo_pkg::REG_WAVE_SELECT: cfg_wave = lfo_pkg::wave_type'(data[1:0]);
         lfo_pkg::REG_AMPLITUDE:   cfg_gain = data[lfo_pkg::AMP_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Advance the oscillator by one request and return the response it must produce.
   function automatic level_result_type advance_lfo(logic [1:0] mode, logic [15:0] sample);
      level_result_type result;
      logic [32:0]      sum;
      logic [7:0]       slot;
      int               base;
      result = '0;
      case (mode)
         lfo_pkg::MODE_TICK: begin
            if (cfg_wave != lfo_pkg::WAVE_HOLD) begin
               sum = {1'b0, lfo_phase} + {1'b0, cfg_step};
               result.full_cycle = sum[32];
               // a wrap rearms the midpoint flag and suppresses it on that tick
               if (sum[32]) begin
                  midpoint_seen = 1'b0;
               end
               lfo_phase = sum[31:0];
               if (!sum[32] && lfo_phase[31] && !midpoint_seen) begin
                  midpoint_seen     = 1'b1;
                  result.half_cycle = 1'b1;
               end
               case (cfg_wave)
                  lfo_pkg::WAVE_DOWN: base = 32767 - int'(lfo_phase[31:16]);
                  lfo_pkg::WAVE_UP:   base = int'(lfo_phase[31:16]) - 32768;
                  default: begin
                     // odd quadrants read the table backwards, upper half negates
                     slot = lfo_phase[30] ? ~lfo_phase[29:22] : lfo_phase[29:22];
                     base = lfo_phase[31] ? -int'(quarter_wave[slot])
                                          : int'(quarter_wave[slot]);
                  end
               endcase
               last_level = apply_gain(base, cfg_gain);
            end
         end
         lfo_pkg::MODE_PHASE_RESET: begin
            lfo_phase     = '0;
            midpoint_seen = 1'b0;
         end
         lfo_pkg::MODE_TRIGGER: begin
            if (cfg_wave == lfo_pkg::WAVE_HOLD) begin
               last_level = apply_gain(int'(sample) - 32768, cfg_gain);
            end
         end
         default: ;
      endcase
      result.level          = last_level;
      result.level_unsigned = last_level ^ 16'h8000;
      return result;
   endfunction

   // Present one request transfer; call and return at a falling edge.
   task automatic send_item(input logic [1:0] mode, input logic [15:0] sample,
                            input logic known, input level_result_type typed);
      level_result_type predicted;
      // drop valid for a random gap once the current burst is used up
      if (gaps_enabled && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid       = 1'b1;
      req_mode        = mode;
      req_hold_sample = sample;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = advance_lfo(mode, sample);
      pending_levels.push_back(known ? typed : predicted);
      if (burst_left != 0) begin
         burst_left--;
      end
      @(negedge clock);
   endtask

   // Let every pending response drain so the unit is idle before a CSR write.
   task automatic settle();
      req_valid = 1'b0;
      while (pending_levels.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [lfo_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      apply_csr(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: pick a new stall pattern each time pattern_age wraps (none, light,
   // heavy, periodic, long holds) so back-pressure lands on every pipeline phase.
   always @(negedge clock) begin
      pattern_age++;
      if (pattern_age == 160) begin
         pattern_age   = 0;
         stall_pattern = $urandom_range(0, 4);
      end
      case (stall_pattern)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         2: rsp_stall = ($urandom_range(0, 9) < 6);
         3: rsp_stall = ((pattern_age % 7) < 3);
         default: begin
            if (stall_hold != 0) begin
               stall_hold--;
               rsp_stall = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_hold = $urandom_range(8, 20);
               rsp_stall  = 1'b1;
            end else begin
               rsp_stall = 1'b0;
            end
         end
      endcase
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // Response monitor and run watchdog.
   always @(posedge clock) begin
      level_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d responses pending",
                cycle_count, pending_levels.size());
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $error("response transfer with nothing pending: level %h", rsp_level);
            mismatches++;
         end else begin
            want = pending_levels.pop_front();
            check_field("level", want.level, rsp_level);
            check_field("level_unsigned", want.level_unsigned, rsp_level_unsigned);
            check_field("half_cycle", 16'(want.half_cycle), 16'(rsp_half_cycle));
            check_field("full_cycle", 16'(want.full_cycle), 16'(rsp_full_cycle));
         end
      end
   end

   initial begin
      logic [31:0]      data;
      logic [1:0]       mode;
      logic [15:0]      sample;
      int unsigned      roll;
      int unsigned      count;
      level_result_type typed;

      for (int i = 0; i < SINE_ENTRIES; i++) begin
         quarter_wave[i] = quarter_wave_value(i);
      end

      // hold reset, then release it away from the sampling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: walk the table.
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED_ROWS[r].is_write) begin
            settle();
            write_csr(DIRECTED_ROWS[r].target, DIRECTED_ROWS[r].value);
         end else begin
            typed.level          = DIRECTED_ROWS[r].level;
            typed.level_unsigned = DIRECTED_ROWS[r].level_unsigned;
            typed.half_cycle     = DIRECTED_ROWS[r].half_cycle;
            typed.full_cycle     = DIRECTED_ROWS[r].full_cycle;
            send_item(DIRECTED_ROWS[r].target, DIRECTED_ROWS[r].value[15:0],
                      DIRECTED_ROWS[r].known, typed);
         end
      end

      // Random part: each phase rewrites every register, then streams requests.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case ($urandom_range(0, 7))
            0: data = 32'h0000_0000;
            1: data = 32'hFFFF_FFFF;
            2: data = 32'h0000_0001;
            3: data = 32'h8000_0000;
            5: data = $urandom_range(1, 32'h00FF_FFFF);
            6: data = 32'h4000_0000 + $urandom_range(0, 32'h0000_FFFF);
            default: data = $urandom;
         endcase
         write_csr(lfo_pkg::REG_PHASE_STEP, data);
         // junk in the unused write bits must be ignored
         data      = $urandom;
         data[1:0] = 2'($urandom_range(0, 3));
         write_csr(lfo_pkg::REG_WAVE_SELECT, data);
         data = $urandom;
         case ($urandom_range(0, 4))
            0: data[lfo_pkg::AMP_BITS-1:0] = '0;
            1: data[lfo_pkg::AMP_BITS-1:0] = 15'd1;
            2: data[lfo_pkg::AMP_BITS-1:0] = 15'h7FFF;
            3: data[lfo_pkg::AMP_BITS-1:0] = 15'h4000;
            default: ;
         endcase
         write_csr(lfo_pkg::REG_AMPLITUDE, data);
         if ($urandom_range(0, 3) == 0) begin
            write_csr(REG_UNUSED, $urandom);
         end

         gaps_enabled = ($urandom_range(0, 3) != 0);
         count        = $urandom_range(40, 100);
         repeat (count) begin
            roll = $urandom_range(0, 99);
            // lean on triggers while holding, on ticks otherwise
            if (cfg_wave == lfo_pkg::WAVE_HOLD) begin
               mode = (roll < 50) ? lfo_pkg::MODE_TRIGGER :
                      (roll < 85) ? lfo_pkg::MODE_TICK :
                      (roll < 93) ? lfo_pkg::MODE_PHASE_RESET : MODE_UNUSED;
            end else begin
               mode = (roll < 75) ? lfo_pkg::MODE_TICK :
                      (roll < 83) ? lfo_pkg::MODE_PHASE_RESET :
                      (roll < 93) ? lfo_pkg::MODE_TRIGGER : MODE_UNUSED;
            end
            case ($urandom_range(0, 9))
               0: sample = 16'h0000;
               1: sample = 16'hFFFF;
               default: sample = 16'($urandom);
            endcase
            send_item(mode, sample, 1'b0, '0);
         end
      end

      // Drain, then keep clocking the pipeline to show any stray transfer.
      req_valid = 1'b0;
      while (pending_levels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
